@@ rtl/cst_pkg.sv @@
// Package: shared types, constants and codes for the column statistics table.
package cst_pkg;

  localparam int MaxRows    = 256;
  localparam int MaxColumns = 16;
  localparam int RowW       = $clog2(MaxRows);
  localparam int ColW       = $clog2(MaxColumns);
  localparam int Depth      = MaxRows * MaxColumns;
  localparam int AddrW      = $clog2(Depth);
  localparam int SeenSpan   = 201;
  localparam int SeenW      = $clog2(SeenSpan);

  localparam logic signed [7:0] EmptyMark  = 8'sd101;
  localparam logic signed [7:0] ValueFloor = -8'sd100;
  localparam logic signed [7:0] ValueCeil  = 8'sd100;

  localparam logic [2:0] ModeWrite    = 3'd0;
  localparam logic [2:0] ModeSum      = 3'd1;
  localparam logic [2:0] ModeAvg      = 3'd2;
  localparam logic [2:0] ModeMax      = 3'd3;
  localparam logic [2:0] ModeMin      = 3'd4;
  localparam logic [2:0] ModeDistinct = 3'd5;
  localparam logic [2:0] ModeClear    = 3'd6;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNoData  = 2'd1;
  localparam logic [1:0] StatusBadCol  = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT,      // sweep store to empty
    ST_IDLE,
    ST_SEEN_CLR,  // sweep seen flags
    ST_SCAN,      // issue reads
    ST_DIV,       // restoring divide for average
    ST_OUT
  } state_t;

endpackage

@@ rtl/cst_ram.sv @@
// Generic RAM with one write port and one registered read port.
module cst_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/column_statistics_table.sv @@
// Top level: column statistics table with sequential scan and a divider for the average.
// Per item, R = rows in use: write, bad column and unused mode skip the scan; a query
//   scans R rows; distinct first sweeps the seen flags, average divides after the scan.
// Clear table sweeps all 4096 cells to empty; the result waits while out_tready is low.
// One item at a time: in_tready stays low until the result beat is taken.
// Reset (synchronous, rst_n low): 4096-cell store sweep, rows 0, columns 16; items wait.
module column_statistics_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] mode, [10:3] row_index, [14:11] column_index, [22:15] cell_value,
  // [23] cell_empty
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] stat_value, [31:16] average_fixed, [33:32] status, zero fill
  output logic [39:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  cst_pkg::state_t state_r, state_nxt;

  logic [4:0]  cols_r;
  logic [8:0]  rows_r, rows_nxt;
  logic [cst_pkg::AddrW-1:0] ptr_r, ptr_nxt;     // store / seen-flag sweep counter
  logic [8:0]  rcnt_r, rcnt_nxt;                 // rows issued
  logic        rvld_r, rvld_nxt;                 // read data valid next cycle
  logic [2:0]  mode_r, mode_nxt;
  logic [cst_pkg::ColW-1:0] col_r, col_nxt;
  logic signed [16:0] sum_r, sum_nxt;            // |sum| <= 25600
  logic [8:0]  cnt_r, cnt_nxt;
  logic signed [7:0] hi_r, hi_nxt, lo_r, lo_nxt;
  logic [8:0]  dist_r, dist_nxt;
  logic [5:0]  dstep_r, dstep_nxt;
  logic [23:0] quo_r, quo_nxt;                   // dividend shifts into quotient
  logic [9:0]  rem_r, rem_nxt;
  logic signed [15:0] stat_r, stat_nxt, avg_r, avg_nxt;
  logic [1:0]  status_r, status_nxt;

  // seen-flag lookup stage: slot in flight and the slot set in the cycle before
  logic        sv_r, sv_nxt;
  logic [cst_pkg::SeenW-1:0] sslot_r, sslot_nxt;
  logic        lw_r, lw_nxt;
  logic [cst_pkg::SeenW-1:0] lslot_r, lslot_nxt;

  // unpack input beat
  logic [2:0] in_mode;
  logic [7:0] in_row;
  logic [3:0] in_col;
  logic signed [7:0] in_val;
  logic in_emp;
  assign in_mode = in_tdata[2:0];
  assign in_row  = in_tdata[10:3];
  assign in_col  = in_tdata[14:11];
  assign in_val  = in_tdata[22:15];
  assign in_emp  = in_tdata[23];

  logic in_fire;
  assign in_tready = (state_r == cst_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = (state_r == cst_pkg::ST_OUT);
  assign out_tdata  = {6'd0, status_r, avg_r, stat_r};

  // ram ports
  logic we;
  logic [cst_pkg::AddrW-1:0] waddr, raddr;
  logic [7:0] wdata, rdata;
  logic signed [7:0] rcell;
  assign rcell = rdata;

  cst_ram #(.Width(8), .Depth(cst_pkg::Depth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic col_ok;
  assign col_ok = ({1'b0, in_col} < cols_r);

  logic signed [7:0] sat_val;
  always_comb begin
    sat_val = in_val;
    if (in_val < cst_pkg::ValueFloor) sat_val = cst_pkg::ValueFloor;
    if (in_val > cst_pkg::ValueCeil)  sat_val = cst_pkg::ValueCeil;
  end

  logic cell_ok;
  logic [cst_pkg::SeenW-1:0] slot;
  assign cell_ok = (rcell >= cst_pkg::ValueFloor) && (rcell <= cst_pkg::ValueCeil);
  assign slot    = cst_pkg::SeenW'(9'(rcell) - 9'(cst_pkg::ValueFloor));

  // seen flags, one per value; read at the slot of the cell just read
  logic seen_we, seen_wdata, seen_rdata, seen_hit;
  logic [cst_pkg::SeenW-1:0] seen_waddr;

  cst_ram #(.Width(1), .Depth(cst_pkg::SeenSpan)) u_seen (
    .clk(clk), .we(seen_we), .waddr(seen_waddr), .wdata(seen_wdata), .raddr(slot),
    .rdata(seen_rdata)
  );

  // the flag written last cycle is not yet in the read data: forward it
  assign seen_hit = seen_rdata || (lw_r && (lslot_r == sslot_r));

  logic [9:0] trial;
  assign trial = {rem_r[8:0], quo_r[23]};

  logic scan_done;
  assign scan_done = (rcnt_r == rows_r) && !rvld_r && !sv_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cst_pkg::ST_INIT: begin
        // a clear item reports once the sweep ends; reset goes straight to idle
        if (ptr_r == cst_pkg::AddrW'(cst_pkg::Depth - 1)) begin
          state_nxt = (mode_r == cst_pkg::ModeClear) ? cst_pkg::ST_OUT : cst_pkg::ST_IDLE;
        end
      end
      cst_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_mode == cst_pkg::ModeClear) begin
            state_nxt = cst_pkg::ST_INIT;
          end else if (in_mode == cst_pkg::ModeDistinct && col_ok) begin
            state_nxt = cst_pkg::ST_SEEN_CLR;
          end else if (in_mode >= cst_pkg::ModeSum && in_mode <= cst_pkg::ModeMin && col_ok) begin
            state_nxt = cst_pkg::ST_SCAN;
          end else begin
            state_nxt = cst_pkg::ST_OUT;
          end
        end
      end
      cst_pkg::ST_SEEN_CLR: begin
        if (ptr_r == cst_pkg::AddrW'(cst_pkg::SeenSpan - 1)) state_nxt = cst_pkg::ST_SCAN;
      end
      cst_pkg::ST_SCAN: begin
        if (scan_done) begin
          if (mode_r == cst_pkg::ModeAvg && cnt_r != 9'd0) state_nxt = cst_pkg::ST_DIV;
          else state_nxt = cst_pkg::ST_OUT;
        end
      end
      cst_pkg::ST_DIV: begin
        if (dstep_r == 6'd23) state_nxt = cst_pkg::ST_OUT;
      end
      cst_pkg::ST_OUT: begin
        if (out_tready) state_nxt = cst_pkg::ST_IDLE;
      end
      default: state_nxt = cst_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rows_nxt = rows_r; ptr_nxt = ptr_r; rcnt_nxt = rcnt_r; rvld_nxt = 1'b0;
    mode_nxt = mode_r; col_nxt = col_r; sum_nxt = sum_r; cnt_nxt = cnt_r;
    hi_nxt = hi_r; lo_nxt = lo_r; dist_nxt = dist_r; dstep_nxt = dstep_r;
    quo_nxt = quo_r; rem_nxt = rem_r; stat_nxt = stat_r; avg_nxt = avg_r;
    status_nxt = status_r;
    sv_nxt = 1'b0; sslot_nxt = sslot_r; lw_nxt = sv_r; lslot_nxt = sslot_r;
    we = 1'b0; waddr = ptr_r; wdata = cst_pkg::EmptyMark;
    raddr = {rcnt_r[cst_pkg::RowW-1:0], col_r};
    seen_we = 1'b0; seen_waddr = sslot_r; seen_wdata = 1'b1;
    case (state_r)
      cst_pkg::ST_INIT: begin
        // sweep one cell per cycle to empty
        we = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        rows_nxt = 9'd0;
      end
      cst_pkg::ST_IDLE: begin
        ptr_nxt = '0; rcnt_nxt = 9'd0;
        sum_nxt = '0; cnt_nxt = 9'd0; dist_nxt = 9'd0;
        hi_nxt = cst_pkg::ValueFloor; lo_nxt = cst_pkg::EmptyMark;
        stat_nxt = '0; avg_nxt = '0; status_nxt = cst_pkg::StatusOk;
        mode_nxt = in_mode; col_nxt = in_col; dstep_nxt = 6'd0;
        if (in_fire) begin
          if (in_mode <= cst_pkg::ModeDistinct && !col_ok) begin
            status_nxt = cst_pkg::StatusBadCol;
          end else if (in_mode == cst_pkg::ModeWrite) begin
            we = 1'b1;
            waddr = {in_row, in_col};
            wdata = in_emp ? cst_pkg::EmptyMark : sat_val;
            if ({1'b0, in_row} + 9'd1 > rows_r) rows_nxt = {1'b0, in_row} + 9'd1;
          end
        end
      end
      cst_pkg::ST_SEEN_CLR: begin
        ptr_nxt = ptr_r + 1'b1;
        seen_we = 1'b1;
        seen_waddr = ptr_r[cst_pkg::SeenW-1:0];
        seen_wdata = 1'b0;
      end
      cst_pkg::ST_SCAN: begin
        // issue one read per cycle, accumulate the cell read last cycle
        if (rcnt_r != rows_r) begin
          rcnt_nxt = rcnt_r + 9'd1;
          rvld_nxt = 1'b1;
        end
        if (rvld_r && cell_ok) begin
          sum_nxt = sum_r + 17'(rcell);
          cnt_nxt = cnt_r + 9'd1;
          if (rcell > hi_r) hi_nxt = rcell;
          if (rcell < lo_r) lo_nxt = rcell;
          if (mode_r == cst_pkg::ModeDistinct) begin
            sv_nxt = 1'b1;
            sslot_nxt = slot;
          end
        end
        // count a value the first time its flag is found clear, then set the flag
        if (sv_r && !seen_hit) begin
          seen_we = 1'b1;
          dist_nxt = dist_r + 9'd1;
        end
        if (scan_done) begin
          case (mode_r)
            cst_pkg::ModeSum:      stat_nxt = sum_r[15:0];
            cst_pkg::ModeMax:      stat_nxt = 16'(hi_r);
            cst_pkg::ModeMin:      stat_nxt = 16'(lo_r);
            cst_pkg::ModeDistinct: stat_nxt = {7'd0, dist_r};
            cst_pkg::ModeAvg: begin
              if (cnt_r == 9'd0) status_nxt = cst_pkg::StatusNoData;
            end
            default: stat_nxt = '0;
          endcase
          // |sum| * 256 into the divider
          quo_nxt = {sum_r[16] ? 16'(-sum_r) : sum_r[15:0], 8'd0};
          rem_nxt = '0;
        end
      end
      cst_pkg::ST_DIV: begin
        // one restoring step per cycle
        dstep_nxt = dstep_r + 6'd1;
        if (trial >= {1'b0, cnt_r}) begin
          rem_nxt = trial - {1'b0, cnt_r};
          quo_nxt = {quo_r[22:0], 1'b1};
        end else begin
          rem_nxt = trial;
          quo_nxt = {quo_r[22:0], 1'b0};
        end
        if (dstep_r == 6'd23) begin
          avg_nxt = sum_r[16] ? -(quo_nxt[15:0]) : quo_nxt[15:0];
        end
      end
      cst_pkg::ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cst_pkg::ST_INIT;
      cols_r  <= 5'd16;
      rows_r  <= 9'd0;
      ptr_r   <= '0;
      rcnt_r  <= 9'd0;
      rvld_r  <= 1'b0;
      mode_r  <= cst_pkg::ModeWrite;
      sv_r    <= 1'b0;
      lw_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) cols_r <= cfg_data;
      rows_r  <= rows_nxt;
      ptr_r   <= ptr_nxt;
      rcnt_r  <= rcnt_nxt;
      rvld_r  <= rvld_nxt;
      mode_r  <= mode_nxt;
      sv_r    <= sv_nxt;
      lw_r    <= lw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt; sum_r <= sum_nxt; cnt_r <= cnt_nxt;
    hi_r <= hi_nxt; lo_r <= lo_nxt; dist_r <= dist_nxt; dstep_r <= dstep_nxt;
    quo_r <= quo_nxt; rem_r <= rem_nxt; stat_r <= stat_nxt; avg_r <= avg_nxt;
    status_r <= status_nxt; sslot_r <= sslot_nxt; lslot_r <= lslot_nxt;
  end

`ifndef SYNTHESIS
  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rows_r <= 9'(cst_pkg::MaxRows)) else $error("rows_in_use overflow");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= rows_r) else $error("scan past rows in use");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata)) else $error("result changed");
  a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cst_pkg::ST_SCAN) |-> !in_tready) else $error("ready during scan");
`endif

endmodule

@@ tb/tb.sv @@
// Testbench for the column statistics table: directed and random items, self-checking.
`timescale 1ns / 100ps

module tb;

  localparam logic [2:0] ModeUnused = 3'd7;

  typedef struct packed {
    logic signed [15:0] stat;
    logic signed [15:0] avg;
    logic [1:0]         status;
  } column_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;

  column_statistics_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the table, its row count and the column register.
  logic signed [7:0] shadow_cells [cst_pkg::MaxRows][cst_pkg::MaxColumns];
  int                shadow_rows;
  int                shadow_columns;

  column_result_t pending_stats[$];
  int             mismatches;
  int             items_sent;
  int             results_seen;
  int             sender_idle_pct;
  int             receiver_stall_pct;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return 16'(v);
  endfunction

  // Work out the result of one item and update the shadow table.
  function automatic column_result_t predict_column_stat(logic [2:0] mode, logic [7:0] row,
      logic [3:0] col, logic signed [7:0] value, logic empty);
    column_result_t res;
    int sum;
    int count;
    int hi;
    int lo;
    int distinct;
    int num;
    int quo;
    int c;
    int v;
    logic [cst_pkg::SeenSpan-1:0] seen;
    res = '0;
    if (mode == cst_pkg::ModeClear) begin
      foreach (shadow_cells[i, j]) shadow_cells[i][j] = cst_pkg::EmptyMark;
      shadow_rows = 0;
    end else if (mode <= cst_pkg::ModeDistinct && int'(col) >= shadow_columns) begin
      res.status = cst_pkg::StatusBadCol;
    end else if (mode == cst_pkg::ModeWrite) begin
      v = int'(value);
      if (v < -100) v = -100;
      if (v > 100) v = 100;
      shadow_cells[row][col] = empty ? cst_pkg::EmptyMark : 8'(v);
      if (int'(row) + 1 > shadow_rows) shadow_rows = int'(row) + 1;
    end else if (mode <= cst_pkg::ModeDistinct) begin
      sum = 0; count = 0; hi = -100; lo = 101; distinct = 0; seen = '0;
      for (int r = 0; r < shadow_rows; r++) begin
        c = int'(shadow_cells[r][col]);
        if (c == 101 || c < -100 || c > 100) continue;
        sum += c;
        count++;
        if (c > hi) hi = c;
        if (c < lo) lo = c;
        if (!seen[c + 100]) begin
          seen[c + 100] = 1'b1;
          distinct++;
        end
      end
      case (mode)
        cst_pkg::ModeSum: res.stat = sat16(sum);
        cst_pkg::ModeAvg: begin
          if (count == 0) begin
            res.status = cst_pkg::StatusNoData;
          end else begin
            num = sum * 256;
            quo = (num < 0 ? -num : num) / count;
            res.avg = sat16(num < 0 ? -quo : quo);
          end
        end
        cst_pkg::ModeMax: res.stat = 16'(hi);
        cst_pkg::ModeMin: res.stat = 16'(lo);
        default: res.stat = sat16(distinct);
      endcase
    end
    return res;
  endfunction

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    column_result_t got;
    column_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.stat   = out_tdata[15:0];
      got.avg    = out_tdata[31:16];
      got.status = out_tdata[33:32];
      results_seen++;
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", out_tdata);
      end else begin
        want = pending_stats.pop_front();
        if (got.stat !== want.stat || got.avg !== want.avg || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: stat %0d avg %0d status %0d, expected %0d %0d %0d",
                     got.stat, got.avg, got.status, want.stat, want.avg, want.status);
        end
      end
    end
  end

  // Stall the result side at the current rate.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Send one item; valid stays high on return so back-to-back beats need no drop.
  task automatic send_item(logic [2:0] mode, logic [7:0] row, logic [3:0] col,
      logic signed [7:0] value, logic empty);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {empty, value, col, row, mode};
    do @(posedge clk); while (!in_tready);
    pending_stats = {pending_stats, predict_column_stat(mode, row, col, value, empty)};
    items_sent++;
  endtask

  // Drop valid and hold until every outstanding result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_columns(logic [4:0] n);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_columns = int'(n);
  endtask

  task automatic query_all_modes(logic [3:0] col);
    for (int m = cst_pkg::ModeSum; m <= cst_pkg::ModeDistinct; m++)
      send_item(3'(m), '0, col, '0, 1'b0);
  endtask

  task automatic test_directed();
    sender_idle_pct = 0; receiver_stall_pct = 0;
    send_item(cst_pkg::ModeAvg, 8'd0, 4'd0, 8'sd0, 1'b0);          // empty table average
    query_all_modes(4'd0);                                        // empty column results
    send_item(cst_pkg::ModeWrite, 8'd0,   4'd15, 8'sd127, 1'b0);  // saturates high
    send_item(cst_pkg::ModeWrite, 8'd255, 4'd15, -8'sd128, 1'b0); // saturates low, last row
    send_item(cst_pkg::ModeWrite, 8'd7,   4'd15, 8'sd100, 1'b0);
    send_item(cst_pkg::ModeWrite, 8'd8,   4'd15, 8'sd55, 1'b1);   // empty marker
    send_item(cst_pkg::ModeWrite, 8'd9,   4'd15, -8'sd3, 1'b0);
    query_all_modes(4'd15);
    send_item(ModeUnused, 8'hff, 4'hf, -8'sd1, 1'b1);
    write_columns(5'd1);                                          // narrowest table
    send_item(cst_pkg::ModeWrite, 8'd3, 4'd1, 8'sd5, 1'b0);       // ignored, bad column
    send_item(cst_pkg::ModeMax, 8'd0, 4'd15, 8'sd0, 1'b0);
    send_item(cst_pkg::ModeSum, 8'd0, 4'd0, 8'sd0, 1'b0);
    write_columns(5'd16);
    send_item(cst_pkg::ModeMin, 8'd0, 4'd15, 8'sd0, 1'b0);
    send_item(cst_pkg::ModeClear, 8'd0, 4'd0, 8'sd0, 1'b0);
    send_item(cst_pkg::ModeSum, 8'd0, 4'd15, 8'sd0, 1'b0);
    drain_results();
  endtask

  // Mostly writes and queries on a small table; rare wide rows, odd values and clears.
  task automatic random_item();
    int pick;
    logic [2:0] mode;
    logic [7:0] row;
    logic signed [7:0] value;
    pick = $urandom_range(999);
    if (pick < 3) mode = cst_pkg::ModeClear;
    else if (pick < 20) mode = ModeUnused;
    else if (pick < 550) mode = cst_pkg::ModeWrite;
    else mode = 3'($urandom_range(cst_pkg::ModeDistinct, cst_pkg::ModeSum));
    row = ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(31));
    value = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(200) - 100);
    send_item(mode, row, 4'($urandom_range(15)), value, $urandom_range(7) == 0);
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, logic [4:0] columns, int n);
    write_columns(columns);
    sender_idle_pct = idle_pct; receiver_stall_pct = stall_pct;
    for (int k = 0; k < n; k++) begin
      random_item();
      if (k == n / 2) drain_results();                   // pause until all results are back
    end
    drain_results();
  endtask

  initial begin
    rst_n <= 1'b0; in_tvalid <= 1'b0; in_tdata <= '0; cfg_valid <= 1'b0; cfg_data <= '0;
    foreach (shadow_cells[i, j]) shadow_cells[i][j] = cst_pkg::EmptyMark;
    shadow_rows = 0; shadow_columns = 16;
    mismatches = 0; items_sent = 0; results_seen = 0;
    sender_idle_pct = 0; receiver_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_phase(0, 0, 5'd16, 240);
    test_random_phase(79, 0, 5'd9, 230);
    test_random_phase(0, 79, 5'd1, 100);
    test_random_phase(0, 79, 5'd16, 130);
    test_random_phase(35, 35, 5'd12, 230);
    drain_results();
    repeat (20) @(posedge clk);
    $display("Sent %0d items over five idle/stall phases and column counts 1..16;",
             items_sent);
    $display("checked %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cst_pkg.sv
rtl/cst_ram.sv
rtl/column_statistics_table.sv
tb/tb.sv
